### rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, state encoding and control bundles for the paging MMU.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 128;
    localparam int TLB_ENTRIES = 16;   // power of two: ring positions wrap naturally
    localparam int PAGE_BYTES  = 256;

    localparam int VPAGE_W   = 8;      // width of the virtual page port
    localparam int OFFSET_W  = 8;      // width of the page offset port
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int BYTE_W    = $clog2(PAGE_BYTES);
    localparam int PADDR_W   = 15;
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int TLB_CNT_W = $clog2(TLB_ENTRIES + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } tlbpt_state_t;

    typedef struct packed {
        logic capture;   // take the input item, launch memory reads
        logic commit;    // update tables and load the result register
    } tlbpt_cmd_t;

    typedef struct packed {
        logic out_free;  // result register empty or being drained
    } tlbpt_status_t;

endpackage

### rtl/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Two-state sequencer: accept an item, then resolve it once the result
// register can take it.
// ----------------------------------------------------------------------------
module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tlbpt_status_t status,
    output tlbpt_cmd_t    cmd
);

    tlbpt_state_t state_reg;
    tlbpt_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_LOOKUP: begin
                cmd.commit = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/tlbpt_datapath.sv
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB registers, page table and frame owner memories, frame allocator and
// the result register.
// ----------------------------------------------------------------------------
module tlbpt_datapath
    import tlbpt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tlbpt_cmd_t           cmd,
    output tlbpt_status_t        status,
    input  logic [VPAGE_W-1:0]   s_virtual_page,
    input  logic [OFFSET_W-1:0]  s_page_offset,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAME_W-1:0]   m_frame_number,
    output logic [PADDR_W-1:0]   m_physical_address,
    output logic                 m_tlb_hit,
    output logic                 m_fault,
    output logic                 m_evicted_valid,
    output logic [VPAGE_W-1:0]   m_evicted_page
);

    // memories
    logic [FRAME_W-1:0] pt_frame_mem    [PAGE_COUNT];
    logic [PAGE_W-1:0]  frame_owner_mem [FRAME_COUNT];
    logic [PAGE_COUNT-1:0] pt_valid_reg;
    logic [PAGE_COUNT-1:0] pt_valid_next;

    // TLB
    logic                 tlb_valid_reg [TLB_ENTRIES];
    logic                 tlb_valid_next [TLB_ENTRIES];
    logic [PAGE_W-1:0]    tlb_page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0]   tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_IDX_W-1:0] tlb_oldest_reg;
    logic [TLB_IDX_W-1:0] tlb_oldest_next;
    logic [TLB_CNT_W-1:0] tlb_fill_reg;
    logic [TLB_CNT_W-1:0] tlb_fill_next;

    // allocator
    logic [FRAME_W-1:0] next_frame_reg;
    logic               memory_full_reg;

    // captured item and read data
    logic [PAGE_W-1:0]  page_reg;
    logic [BYTE_W-1:0]  offset_reg;
    logic [FRAME_W-1:0] pt_frame_rd_reg;
    logic [PAGE_W-1:0]  owner_rd_reg;

    // lookup results
    logic                 hit_now;
    logic [FRAME_W-1:0]   hit_frame;
    logic                 present_now;
    logic                 fault_now;
    logic                 evict_now;
    logic                 append_now;
    logic [FRAME_W-1:0]   frame_now;
    logic [TLB_IDX_W-1:0] slot_now;
    logic                 tlb_full;

    logic                 m_valid_reg;

    // ------------------------------------------------------------------
    // capture and memory reads
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            page_reg        <= s_virtual_page[PAGE_W-1:0];
            offset_reg      <= s_page_offset[BYTE_W-1:0];
            pt_frame_rd_reg <= pt_frame_mem[s_virtual_page[PAGE_W-1:0]];
            owner_rd_reg    <= frame_owner_mem[next_frame_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && fault_now) begin
            pt_frame_mem[page_reg]          <= next_frame_reg;
            frame_owner_mem[next_frame_reg] <= page_reg;
        end
    end

    // ------------------------------------------------------------------
    // lookup
    // ------------------------------------------------------------------
    always_comb begin
        hit_now   = 1'b0;
        hit_frame = '0;
        // walk downward so the lowest matching slot wins
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page_reg)) begin
                hit_now   = 1'b1;
                hit_frame = tlb_frame_reg[i];
            end
        end
    end

    assign present_now = pt_valid_reg[page_reg];
    assign fault_now   = !hit_now && !present_now;
    assign evict_now   = fault_now && memory_full_reg;
    assign append_now  = !hit_now;

    always_comb begin
        priority if (hit_now) begin
            frame_now = hit_frame;
        end else if (present_now) begin
            frame_now = pt_frame_rd_reg;
        end else begin
            frame_now = next_frame_reg;
        end
    end

    assign tlb_full = (tlb_fill_reg == TLB_CNT_W'(TLB_ENTRIES));

    always_comb begin
        tlb_oldest_next = tlb_oldest_reg;
        tlb_fill_next   = tlb_fill_reg;
        if (tlb_full) begin
            slot_now = tlb_oldest_reg;
            if (cmd.commit && append_now) begin
                tlb_oldest_next = tlb_oldest_reg + 1'b1;
            end
        end else begin
            slot_now = tlb_oldest_reg + tlb_fill_reg[TLB_IDX_W-1:0];
            if (cmd.commit && append_now) begin
                tlb_fill_next = tlb_fill_reg + 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_valid_next[i] = tlb_valid_reg[i];
            if (cmd.commit) begin
                // drop the evicted page, then append the new translation
                if (evict_now && (tlb_page_reg[i] == owner_rd_reg)) begin
                    tlb_valid_next[i] = 1'b0;
                end
                if (append_now && (slot_now == TLB_IDX_W'(i))) begin
                    tlb_valid_next[i] = 1'b1;
                end
            end
        end
    end

    // clear the evicted page, then mark the faulted page present
    always_comb begin
        pt_valid_next = pt_valid_reg;
        if (cmd.commit && fault_now) begin
            if (evict_now) begin
                pt_valid_next[owner_rd_reg] = 1'b0;
            end
            pt_valid_next[page_reg] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // state update
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                tlb_valid_reg[i] <= 1'b0;
            end
            tlb_oldest_reg  <= '0;
            tlb_fill_reg    <= '0;
            pt_valid_reg    <= '0;
            next_frame_reg  <= '0;
            memory_full_reg <= 1'b0;
        end else begin
            tlb_valid_reg  <= tlb_valid_next;
            tlb_oldest_reg <= tlb_oldest_next;
            tlb_fill_reg   <= tlb_fill_next;
            pt_valid_reg   <= pt_valid_next;
            if (cmd.commit && fault_now) begin
                if (next_frame_reg == FRAME_W'(FRAME_COUNT - 1)) begin
                    next_frame_reg  <= '0;
                    memory_full_reg <= 1'b1;
                end else begin
                    next_frame_reg <= next_frame_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && append_now) begin
            tlb_page_reg[slot_now]  <= page_reg;
            tlb_frame_reg[slot_now] <= frame_now;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_frame_number     <= frame_now;
            m_physical_address <= PADDR_W'({frame_now, offset_reg});
            m_tlb_hit          <= hit_now;
            m_fault            <= fault_now;
            m_evicted_valid    <= evict_now;
            m_evicted_page     <= evict_now ? VPAGE_W'(owner_rd_reg) : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fault_marks_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && fault_now) |=> pt_valid_reg[$past(page_reg)])
        else $error("faulted page not marked present");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        tlb_fill_reg <= TLB_CNT_W'(TLB_ENTRIES))
        else $error("TLB fill count overflow");

    a_ring_still_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !tlb_full |-> (tlb_oldest_reg == '0))
        else $error("TLB oldest pointer moved before the TLB filled");

    a_hit_excludes_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_tlb_hit && m_fault))
        else $error("result flagged both TLB hit and page fault");

    a_evict_needs_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_evicted_valid |-> m_fault)
        else $error("eviction reported without a page fault");

endmodule

### rtl/tlb_page_table_translate.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translate
// Demand-paging MMU: 16-entry FIFO TLB, 256-entry page table and
// round-robin allocation over 128 frames with eviction of the prior owner.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | virtual_page, page_offset
//   m_      | out       | m_valid / m_ready  | frame_number, physical_address,
//           |           |                    | tlb_hit, fault,
//           |           |                    | evicted_valid, evicted_page
//
// An item is captured in ST_IDLE, which also reads the page table and
// frame owner memories; ST_LOOKUP does the TLB compare, table updates and
// result. A new item is not accepted until the current one commits. A
// pending result in the output register does not block capture of the
// next item, but while m_ready is low it holds that item in ST_LOOKUP.
// Synchronous reset marks every page absent and every TLB entry invalid
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlb_page_table_translate
    import tlbpt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [VPAGE_W-1:0]   s_virtual_page,
    input  logic [OFFSET_W-1:0]  s_page_offset,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAME_W-1:0]   m_frame_number,
    output logic [PADDR_W-1:0]   m_physical_address,
    output logic                 m_tlb_hit,
    output logic                 m_fault,
    output logic                 m_evicted_valid,
    output logic [VPAGE_W-1:0]   m_evicted_page
);

    tlbpt_cmd_t    cmd;
    tlbpt_status_t status;

    tlbpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tlbpt_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_virtual_page     (s_virtual_page),
        .s_page_offset      (s_page_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_number     (m_frame_number),
        .m_physical_address (m_physical_address),
        .m_tlb_hit          (m_tlb_hit),
        .m_fault            (m_fault),
        .m_evicted_valid    (m_evicted_valid),
        .m_evicted_page     (m_evicted_page)
    );

endmodule
